// File: hdl/periodic_timer_queue_assert.svh
// Assertion shorthands used by the timer queue datapath.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef PERIODIC_TIMER_QUEUE_ASSERT_SVH
`define PERIODIC_TIMER_QUEUE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PTQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/ptq_pkg.sv
package ptq_pkg;

  // Sizing of the queue and of the stored task identifiers.
  localparam int QUEUE_DEPTH  = 16;
  localparam int TASK_ID_BITS = 8;
  // Most results that one tick may produce.
  localparam int MAX_RESULTS  = 16;

  localparam int IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int FCNT_W = $clog2(MAX_RESULTS);

  // Input item codes.
  localparam logic MODE_TICK = 1'b1;

  // Result kinds.
  localparam logic [1:0] KIND_ADDED = 2'd0;
  localparam logic [1:0] KIND_PAST  = 2'd1;
  localparam logic [1:0] KIND_FULL  = 2'd2;
  localparam logic [1:0] KIND_FIRED = 2'd3;

  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [TASK_ID_BITS-1:0] task_t;

  typedef struct packed {
    logic        mode;
    logic [7:0]  task_id;
    logic [31:0] due_time;
    logic [31:0] repeat_period;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  fired_task;
    logic [31:0] fire_time;
    logic        last;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic add;
    logic scan;
    logic fire;
    logic flush;
  } ptq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_tick;
    logic out_free;
    logic scan_done;
    logic best_found;
    logic pend_vld;
    logic cap_reached;
  } ptq_stat_t;

endpackage

// File: hdl/ptq_ctrl.sv
module ptq_ctrl import ptq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  ptq_stat_t stat,
  output ptq_cmd_t  cmd
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ADD   = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_FIRE  = 5'b01000,
    ST_FLUSH = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = stat.in_tick ? ST_SCAN : ST_ADD;
        end
      end
      ST_ADD: begin
        if (stat.out_free) begin
          cmd.add   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          priority if (stat.best_found) begin
            state_nxt = ST_FIRE;
          end else if (stat.pend_vld) begin
            state_nxt = ST_FLUSH;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_FIRE: begin
        // A held result moves out first, so the output register must be free.
        if (!stat.pend_vld || stat.out_free) begin
          cmd.fire  = 1'b1;
          state_nxt = stat.cap_reached ? ST_FLUSH : ST_SCAN;
        end
      end
      ST_FLUSH: begin
        if (stat.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

endmodule

// File: hdl/ptq_dpath.sv
module ptq_dpath import ptq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  in_word_t  in_word,
  input  ptq_cmd_t  cmd,
  output ptq_stat_t stat,
  input  logic      out_stall,
  output logic      out_valid,
  output out_word_t out_word
);

  localparam logic [IDX_W:0] SCAN_END = (IDX_W + 1)'(QUEUE_DEPTH);

  // Clock and entry bookkeeping.
  logic [31:0]            clock_now_r, clock_now_nxt;
  logic [QUEUE_DEPTH-1:0] valid_r, valid_nxt;
  idx_t                   rank_r [QUEUE_DEPTH];
  idx_t                   rank_nxt [QUEUE_DEPTH];
  logic [CNT_W-1:0]       count_r, count_nxt;

  // Entry payload memories.
  logic [31:0] due_mem [QUEUE_DEPTH];
  task_t       task_mem [QUEUE_DEPTH];
  logic [31:0] per_mem [QUEUE_DEPTH];
  logic        mem_we;
  idx_t        mem_widx;
  logic [31:0] mem_wdue;
  task_t       mem_wtask;
  logic [31:0] mem_wper;

  in_word_t item_r;

  // Scan pipeline: issue an address, then compare the entry from the registered read port.
  logic [IDX_W:0] scan_idx_r, scan_idx_nxt;
  logic           rd_pend_r, rd_pend_nxt;
  logic           rd_valid_r;
  idx_t           rd_rank_r;
  idx_t           rd_idx_r;
  logic [31:0]    rd_due_r;
  task_t          rd_task_r;
  logic [31:0]    rd_per_r;
  logic           issue;
  idx_t           issue_idx;
  logic           better;

  logic        best_found_r, best_found_nxt;
  logic [31:0] best_due_r;
  idx_t        best_rank_r;
  task_t       best_task_r;
  logic [31:0] best_per_r;
  idx_t        best_idx_r;

  // The fired result waits here until we know whether it is the last one.
  logic        pend_vld_r, pend_vld_nxt;
  task_t       pend_task_r;
  logic [31:0] pend_time_r;

  logic [FCNT_W-1:0] fire_cnt_r, fire_cnt_nxt;

  logic      out_valid_r, out_valid_nxt;
  out_word_t out_word_r;
  logic      push;
  out_word_t push_word;

  idx_t        free_idx;
  logic        full;
  logic        past;
  task_t       item_task;
  logic [32:0] reload_sum;
  logic [31:0] reload_due;
  logic        reload;

  assign issue     = cmd.scan && (scan_idx_r < SCAN_END);
  assign issue_idx = scan_idx_r[IDX_W-1:0];

  assign better = cmd.scan && rd_pend_r && rd_valid_r && (rd_due_r <= clock_now_r) &&
                  (!best_found_r || (rd_due_r < best_due_r) ||
                   ((rd_due_r == best_due_r) && (rd_rank_r < best_rank_r)));

  // Lowest free slot.
  always_comb begin
    free_idx = '0;
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = idx_t'(i);
      end
    end
  end

  assign full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign past      = (item_r.due_time < clock_now_r);
  assign item_task = task_t'(item_r.task_id);

  assign reload_sum = {1'b0, best_due_r} + {1'b0, best_per_r};
  assign reload_due = reload_sum[32] ? '1 : reload_sum[31:0];
  assign reload     = (best_per_r != '0);

  always_comb begin
    clock_now_nxt  = clock_now_r;
    valid_nxt      = valid_r;
    rank_nxt       = rank_r;
    count_nxt      = count_r;
    scan_idx_nxt   = scan_idx_r;
    rd_pend_nxt    = rd_pend_r;
    best_found_nxt = best_found_r;
    pend_vld_nxt   = pend_vld_r;
    fire_cnt_nxt   = fire_cnt_r;
    mem_we         = 1'b0;
    mem_widx       = free_idx;
    mem_wdue       = item_r.due_time;
    mem_wtask      = item_task;
    mem_wper       = item_r.repeat_period;
    push           = 1'b0;
    push_word      = '0;

    if (cmd.accept && (in_word.mode == MODE_TICK)) begin
      if (clock_now_r != '1) begin
        clock_now_nxt = clock_now_r + 32'd1;
      end
      scan_idx_nxt   = '0;
      rd_pend_nxt    = 1'b0;
      best_found_nxt = 1'b0;
      fire_cnt_nxt   = '0;
    end

    if (cmd.add) begin
      push                 = 1'b1;
      push_word.fired_task = 8'(item_task);
      push_word.fire_time  = item_r.due_time;
      push_word.last       = 1'b1;
      priority if (past) begin
        push_word.kind = KIND_PAST;
      end else if (full) begin
        push_word.kind = KIND_FULL;
      end else begin
        push_word.kind     = KIND_ADDED;
        mem_we             = 1'b1;
        valid_nxt[free_idx] = 1'b1;
        rank_nxt[free_idx]  = idx_t'(count_r);
        count_nxt          = count_r + CNT_W'(1);
      end
    end

    if (cmd.scan) begin
      rd_pend_nxt = issue;
      if (issue) begin
        scan_idx_nxt = scan_idx_r + (IDX_W + 1)'(1);
      end
      if (better) begin
        best_found_nxt = 1'b1;
      end
    end

    if (cmd.fire) begin
      if (pend_vld_r) begin
        push                 = 1'b1;
        push_word.kind       = KIND_FIRED;
        push_word.fired_task = 8'(pend_task_r);
        push_word.fire_time  = pend_time_r;
        push_word.last       = 1'b0;
      end
      pend_vld_nxt = 1'b1;
      // Removing the entry closes the gap it leaves in the insertion order.
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        if (valid_r[i] && (rank_r[i] > best_rank_r)) begin
          rank_nxt[i] = rank_r[i] - idx_t'(1);
        end
      end
      if (reload) begin
        rank_nxt[best_idx_r] = idx_t'(count_r - CNT_W'(1));
        mem_we    = 1'b1;
        mem_widx  = best_idx_r;
        mem_wdue  = reload_due;
        mem_wtask = best_task_r;
        mem_wper  = best_per_r;
      end else begin
        valid_nxt[best_idx_r] = 1'b0;
        count_nxt             = count_r - CNT_W'(1);
      end
      fire_cnt_nxt   = fire_cnt_r + FCNT_W'(1);
      scan_idx_nxt   = '0;
      rd_pend_nxt    = 1'b0;
      best_found_nxt = 1'b0;
    end

    if (cmd.flush) begin
      push                 = 1'b1;
      push_word.kind       = KIND_FIRED;
      push_word.fired_task = 8'(pend_task_r);
      push_word.fire_time  = pend_time_r;
      push_word.last       = 1'b1;
      pend_vld_nxt         = 1'b0;
    end

    out_valid_nxt = out_valid_r && out_stall;
    if (push) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Memories: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      due_mem[mem_widx]  <= mem_wdue;
      task_mem[mem_widx] <= mem_wtask;
      per_mem[mem_widx]  <= mem_wper;
    end
    if (issue) begin
      rd_due_r   <= due_mem[issue_idx];
      rd_task_r  <= task_mem[issue_idx];
      rd_per_r   <= per_mem[issue_idx];
      rd_valid_r <= valid_r[issue_idx];
      rd_rank_r  <= rank_r[issue_idx];
      rd_idx_r   <= issue_idx;
    end
  end

  always_ff @(posedge clk) begin
    rank_r <= rank_nxt;
    if (cmd.accept) begin
      item_r <= in_word;
    end
    if (better) begin
      best_due_r  <= rd_due_r;
      best_rank_r <= rd_rank_r;
      best_task_r <= rd_task_r;
      best_per_r  <= rd_per_r;
      best_idx_r  <= rd_idx_r;
    end
    if (cmd.fire) begin
      pend_task_r <= best_task_r;
      pend_time_r <= best_due_r;
    end
    if (push) begin
      out_word_r <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_now_r  <= '0;
      valid_r      <= '0;
      count_r      <= '0;
      scan_idx_r   <= '0;
      rd_pend_r    <= 1'b0;
      best_found_r <= 1'b0;
      pend_vld_r   <= 1'b0;
      fire_cnt_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      clock_now_r  <= clock_now_nxt;
      valid_r      <= valid_nxt;
      count_r      <= count_nxt;
      scan_idx_r   <= scan_idx_nxt;
      rd_pend_r    <= rd_pend_nxt;
      best_found_r <= best_found_nxt;
      pend_vld_r   <= pend_vld_nxt;
      fire_cnt_r   <= fire_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  assign stat.in_tick     = (in_word.mode == MODE_TICK);
  assign stat.out_free    = !out_valid_r || !out_stall;
  assign stat.scan_done   = (scan_idx_r == SCAN_END) && !rd_pend_r;
  assign stat.best_found  = best_found_r;
  assign stat.pend_vld    = pend_vld_r;
  assign stat.cap_reached = (fire_cnt_r == FCNT_W'(MAX_RESULTS - 1));

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  `include "periodic_timer_queue_assert.svh"

  `PTQ_ASSERT_SAME(a_count_tracks_valid, 1'b1, $countones(valid_r) == count_r, "entry count out of step with valid bits")
  `PTQ_ASSERT_SAME(a_fire_needs_best, cmd.fire, best_found_r, "fire issued with no due entry selected")
  `PTQ_ASSERT_SAME(a_no_result_overwrite, out_valid_r && out_stall, !push, "held result overwritten")
  `PTQ_ASSERT_NEXT(a_clock_monotonic, 1'b1, clock_now_r >= $past(clock_now_r), "clock moved backward")

endmodule

// File: hdl/periodic_timer_queue.sv
// Channel   Direction  Ports                           Word type
// input     in         in_valid, in_stall, in_word     in_word_t (add or tick)
// result    out        out_valid, out_stall, out_word  out_word_t (one result)
//
// An add item is accepted and then, in the add step, checked, stored and
// posted as its single result.
// A tick item scans the queue once per fired entry plus once more to find
// nothing left. Each scan reads the entry memories one slot a cycle. A tick
// that reaches the cap of MAX_RESULTS fired entries skips the final scan.
// Reset is synchronous and active low; it empties the queue and zeroes the
// clock at once, with no clearing pass.
// A stall on the result side holds the block only when a new result must
// enter the output register while the previous one is still waiting.
module periodic_timer_queue import ptq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  // The controller sequences accept, add, scan, fire and flush steps; the
  // datapath holds the clock, the entry memories and the output register.
  ptq_cmd_t  cmd;
  ptq_stat_t stat;

  ptq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  ptq_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cmd       (cmd),
    .stat      (stat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule
